/* design/sphere_contact_penalty_kernel_unit_assert.svh */
// ----------------------------------------------------------------------------
// sphere contact penalty kernel assertion macros
// concurrent checks that can be compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef SPHERE_CONTACT_PENALTY_KERNEL_UNIT_ASSERT_SVH
`define SPHERE_CONTACT_PENALTY_KERNEL_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SCPK_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scpk assertion failed");

// next-cycle implication
`define SCPK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scpk assertion failed");

`else

`define SCPK_ASSERT_IMPL(label, clk, rst, ante, cons)

`define SCPK_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* design/scpk_pkg.sv */
// ----------------------------------------------------------------------------
// scpk_pkg
// shared types, constants and fixed-point helpers of the contact kernel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scpk_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SQRT_STEPS = 34;
  localparam int RADW       = 2 * SQRT_STEPS;
  localparam int ROOTW      = SQRT_STEPS;
  localparam int REMW       = ROOTW + 4;
  localparam int MAGW       = 33;
  localparam int DENW       = 31;
  localparam int QBITS      = 31;
  localparam int NUMW       = MAGW + FRAC_BITS;
  localparam int LANES      = 4;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_PENALTY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_COEFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROXIMITY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEWMARK_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DYNAMIC_MODE    = 3'd4;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST  = 2'd2;

  localparam logic signed [31:0] Q_ONE   = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [33:0] SAT_HI  = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SAT_LO  = -34'sh0_8000_0000;

  typedef struct packed {
    logic signed [31:0] particle_x;
    logic signed [31:0] particle_y;
    logic signed [31:0] particle_z;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] node_z;
    logic        [30:0] radius_sum;
    logic signed [31:0] rel_vel_x;
    logic signed [31:0] rel_vel_y;
    logic signed [31:0] rel_vel_z;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  row_index;
    logic signed [31:0] stiff_col_x;
    logic signed [31:0] stiff_col_y;
    logic signed [31:0] stiff_col_z;
    logic signed [31:0] damp_col_x;
    logic signed [31:0] damp_col_y;
    logic signed [31:0] damp_col_z;
    logic signed [31:0] load_component;
    logic               in_contact;
    logic               near;
    logic               last_row;
  } out_item_t;

  typedef struct packed {
    logic [30:0] epn;
    logic [30:0] damp;
    logic [30:0] prox;
    logic [30:0] gain;
    logic        dyn;
  } cfg_t;

  typedef struct packed {
    logic contact;
    logic near;
    logic active;
  } pair_flags_t;

  // carried alongside the square root
  typedef struct packed {
    logic [2:0][31:0]     vel;
    logic [30:0]          rsum;
    logic [2:0]           dsign;
    logic [2:0][MAGW-1:0] dmag;
  } geo_side_t;

  // carried alongside the divider
  typedef struct packed {
    logic [2:0][31:0] vel;
    pair_flags_t      flags;
    logic [31:0]      gn;
  } geo_ctl_t;

  // per-pair geometry handed to the row sequencer
  typedef struct packed {
    logic [2:0][31:0] nrm;
    logic [31:0]      f;
    logic [31:0]      gn;
    logic [2:0][31:0] vel;
    pair_flags_t      flags;
  } geo_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = Q_MAX;
    else if (v < SAT_LO) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [33:0] s;
    s = {{2{a[31]}}, a} + {{2{b[31]}}, b};
    return sat32(s);
  endfunction

  function automatic logic signed [31:0] sadd3(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic signed [31:0] c);
    logic signed [33:0] s;
    s = {{2{a[31]}}, a} + {{2{b[31]}}, b} + {{2{c[31]}}, c};
    return sat32(s);
  endfunction

  // fixed-point product, truncated toward zero, saturated
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic        neg;
    logic [31:0] ua;
    logic [31:0] ub;
    logic [63:0] p;
    logic [63:0] ps;
    logic [31:0] t;
    logic signed [31:0] r;
    neg = a[31] ^ b[31];
    ua  = a[31] ? (~a + 32'd1) : a;
    ub  = b[31] ? (~b + 32'd1) : b;
    p   = {32'd0, ua} * {32'd0, ub};
    ps  = p >> FRAC_BITS;
    t   = ~ps[31:0] + 32'd1;
    if (neg) r = (ps > 64'h8000_0000) ? Q_MIN : $signed(t);
    else     r = (ps > 64'h7FFF_FFFF) ? Q_MAX : $signed(ps[31:0]);
    return r;
  endfunction

endpackage

/* design/scpk_geom.sv */
// ----------------------------------------------------------------------------
// scpk_geom
// centre distance, gap, normal and gap ratio: pipelined root and divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scpk_geom (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  scpk_pkg::cfg_t     cfg,
  input  logic               in_valid,
  input  scpk_pkg::in_item_t in_data,
  output logic               out_valid,
  output scpk_pkg::geo_t     out_data
);

  // delta stage
  logic                           g1_vld;
  scpk_pkg::geo_side_t            g1_side;
  logic [2:0][scpk_pkg::MAGW-1:0] diff;
  scpk_pkg::geo_side_t            g1_next;

  always_comb begin
    diff[0] = {in_data.particle_x[31], in_data.particle_x} - {in_data.node_x[31], in_data.node_x};
    diff[1] = {in_data.particle_y[31], in_data.particle_y} - {in_data.node_y[31], in_data.node_y};
    diff[2] = {in_data.particle_z[31], in_data.particle_z} - {in_data.node_z[31], in_data.node_z};
    g1_next.vel  = {in_data.rel_vel_z, in_data.rel_vel_y, in_data.rel_vel_x};
    g1_next.rsum = in_data.radius_sum;
    for (int l = 0; l < 3; l++) begin
      g1_next.dsign[l] = diff[l][scpk_pkg::MAGW-1];
      g1_next.dmag[l]  = diff[l][scpk_pkg::MAGW-1] ? (~diff[l] + 1'b1) : diff[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_vld <= 1'b0;
    end else if (en) begin
      g1_vld <= in_valid;
    end
    if (en) begin
      g1_side <= g1_next;
    end
  end

  // squares
  logic                             g2_vld;
  scpk_pkg::geo_side_t              g2_side;
  logic [2:0][2*scpk_pkg::MAGW-1:0] g2_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      g2_vld <= 1'b0;
    end else if (en) begin
      g2_vld <= g1_vld;
    end
    if (en) begin
      g2_side <= g1_side;
      for (int l = 0; l < 3; l++) begin
        g2_sq[l] <= {{scpk_pkg::MAGW{1'b0}}, g1_side.dmag[l]}
                  * {{scpk_pkg::MAGW{1'b0}}, g1_side.dmag[l]};
      end
    end
  end

  // square root, one result bit per stage
  logic [scpk_pkg::RADW-1:0]  sq_rad  [0:scpk_pkg::SQRT_STEPS-1];
  logic [scpk_pkg::REMW-1:0]  sq_rem  [0:scpk_pkg::SQRT_STEPS-1];
  logic [scpk_pkg::ROOTW-1:0] sq_root [0:scpk_pkg::SQRT_STEPS];
  scpk_pkg::geo_side_t        sq_side [0:scpk_pkg::SQRT_STEPS];
  logic                       sq_vld  [0:scpk_pkg::SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= g2_vld;
    end
    if (en) begin
      sq_rad[0]  <= scpk_pkg::RADW'(g2_sq[0]) + scpk_pkg::RADW'(g2_sq[1])
                  + scpk_pkg::RADW'(g2_sq[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_side[0] <= g2_side;
    end
  end

  for (genvar s = 0; s < scpk_pkg::SQRT_STEPS; s++) begin : g_sqrt
    logic [scpk_pkg::REMW-1:0] trial;
    logic [scpk_pkg::REMW-1:0] test;
    logic                      hit;

    always_comb begin
      trial = {sq_rem[s][scpk_pkg::REMW-3:0],
               sq_rad[s][2*(scpk_pkg::SQRT_STEPS-1-s) +: 2]};
      test  = scpk_pkg::REMW'({sq_root[s], 2'b01});
      hit   = (trial >= test);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[s+1] <= 1'b0;
      end else if (en) begin
        sq_vld[s+1] <= sq_vld[s];
      end
      if (en) begin
        sq_root[s+1] <= {sq_root[s][scpk_pkg::ROOTW-2:0], hit};
        sq_side[s+1] <= sq_side[s];
      end
    end

    if (s < scpk_pkg::SQRT_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          sq_rem[s+1] <= hit ? (trial - test) : trial;
          sq_rad[s+1] <= sq_rad[s];
        end
      end
    end
  end

  // gap, flags and divider set-up
  logic [scpk_pkg::ROOTW-1:0]                          pd_d;
  scpk_pkg::geo_side_t                                 pd_s;
  scpk_pkg::geo_ctl_t                                  pd_ctl;
  logic [scpk_pkg::LANES-1:0][scpk_pkg::MAGW-1:0]     pd_mag;
  logic [scpk_pkg::LANES-1:0]                          pd_neg;
  logic [scpk_pkg::LANES-1:0]                          pd_ovf;
  logic [scpk_pkg::LANES-1:0][scpk_pkg::NUMW-1:0]     pd_num;
  logic [scpk_pkg::LANES-1:0][scpk_pkg::DENW-1:0]     pd_rem;
  logic [scpk_pkg::DENW-1:0]                           pd_den;

  always_comb begin
    pd_d   = sq_root[scpk_pkg::SQRT_STEPS];
    pd_s   = sq_side[scpk_pkg::SQRT_STEPS];
    pd_den = pd_d[scpk_pkg::DENW-1:0];
    pd_ctl.vel           = pd_s.vel;
    pd_ctl.flags.contact = (pd_d < scpk_pkg::ROOTW'(pd_s.rsum));
    pd_ctl.flags.near    = (pd_d <= scpk_pkg::ROOTW'(cfg.prox));
    pd_ctl.flags.active  = pd_ctl.flags.contact && (pd_d != '0);
    pd_ctl.gn = {1'b0, pd_den} - {1'b0, pd_s.rsum};
    for (int l = 0; l < 3; l++) begin
      pd_mag[l] = pd_s.dmag[l];
      pd_neg[l] = pd_s.dsign[l];
    end
    pd_mag[3] = scpk_pkg::MAGW'(pd_s.rsum - pd_den);
    pd_neg[3] = pd_ctl.gn[31];
    for (int l = 0; l < scpk_pkg::LANES; l++) begin
      pd_ovf[l] = ((64'(pd_mag[l]) << scpk_pkg::FRAC_BITS) >= (64'(pd_den) << scpk_pkg::QBITS));
      pd_num[l] = scpk_pkg::NUMW'(pd_mag[l]) << scpk_pkg::FRAC_BITS;
      pd_rem[l] = scpk_pkg::DENW'(pd_num[l][scpk_pkg::NUMW-1:scpk_pkg::QBITS]);
    end
  end

  // restoring divider, four lanes sharing the distance as divisor
  logic [scpk_pkg::LANES-1:0][scpk_pkg::DENW-1:0]  dv_rem [0:scpk_pkg::QBITS-1];
  logic [scpk_pkg::LANES-1:0][scpk_pkg::NUMW-1:0]  dv_num [0:scpk_pkg::QBITS-1];
  logic [scpk_pkg::DENW-1:0]                        dv_den [0:scpk_pkg::QBITS-1];
  logic [scpk_pkg::LANES-1:0][scpk_pkg::QBITS-1:0] dv_q   [0:scpk_pkg::QBITS];
  logic [scpk_pkg::LANES-1:0]                       dv_neg [0:scpk_pkg::QBITS];
  logic [scpk_pkg::LANES-1:0]                       dv_ovf [0:scpk_pkg::QBITS];
  scpk_pkg::geo_ctl_t                               dv_ctl [0:scpk_pkg::QBITS];
  logic                                             dv_vld [0:scpk_pkg::QBITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= sq_vld[scpk_pkg::SQRT_STEPS];
    end
    if (en) begin
      dv_rem[0] <= pd_rem;
      dv_num[0] <= pd_num;
      dv_den[0] <= pd_den;
      dv_q[0]   <= '0;
      dv_neg[0] <= pd_neg;
      dv_ovf[0] <= pd_ovf;
      dv_ctl[0] <= pd_ctl;
    end
  end

  for (genvar k = 0; k < scpk_pkg::QBITS; k++) begin : g_div
    logic [scpk_pkg::LANES-1:0][scpk_pkg::DENW:0]   trial;
    logic [scpk_pkg::LANES-1:0]                      hit;
    logic [scpk_pkg::LANES-1:0][scpk_pkg::DENW-1:0] rem_next;
    logic [scpk_pkg::LANES-1:0][scpk_pkg::QBITS-1:0] q_next;

    always_comb begin
      for (int l = 0; l < scpk_pkg::LANES; l++) begin
        trial[l]    = {dv_rem[k][l], dv_num[k][l][scpk_pkg::QBITS-1-k]};
        hit[l]      = (trial[l] >= {1'b0, dv_den[k]});
        rem_next[l] = hit[l] ? scpk_pkg::DENW'(trial[l] - {1'b0, dv_den[k]})
                             : trial[l][scpk_pkg::DENW-1:0];
        q_next[l]   = {dv_q[k][l][scpk_pkg::QBITS-2:0], hit[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld[k+1] <= dv_vld[k];
      end
      if (en) begin
        dv_q[k+1]   <= q_next;
        dv_neg[k+1] <= dv_neg[k];
        dv_ovf[k+1] <= dv_ovf[k];
        dv_ctl[k+1] <= dv_ctl[k];
      end
    end

    if (k < scpk_pkg::QBITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[k+1] <= rem_next;
          dv_num[k+1] <= dv_num[k];
          dv_den[k+1] <= dv_den[k];
        end
      end
    end
  end

  // signs and saturation of the quotients
  logic [scpk_pkg::LANES-1:0][31:0] quo;
  logic [31:0]                      qext;
  scpk_pkg::geo_ctl_t               fin_ctl;

  always_comb begin
    fin_ctl = dv_ctl[scpk_pkg::QBITS];
    for (int l = 0; l < scpk_pkg::LANES; l++) begin
      qext = {1'b0, dv_q[scpk_pkg::QBITS][l]};
      if (dv_ovf[scpk_pkg::QBITS][l]) begin
        quo[l] = dv_neg[scpk_pkg::QBITS][l] ? scpk_pkg::Q_MIN : scpk_pkg::Q_MAX;
      end else begin
        quo[l] = dv_neg[scpk_pkg::QBITS][l] ? (~qext + 32'd1) : qext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld[scpk_pkg::QBITS];
    end
    if (en) begin
      out_data.nrm   <= {quo[2], quo[1], quo[0]};
      out_data.f     <= quo[3];
      out_data.gn    <= fin_ctl.gn;
      out_data.vel   <= fin_ctl.vel;
      out_data.flags <= fin_ctl.flags;
    end
  end

endmodule

/* design/scpk_rows.sv */
// ----------------------------------------------------------------------------
// scpk_rows
// stiffness, damping and load of one block row, four stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scpk_rows (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  scpk_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  logic [1:0]          row,
  input  scpk_pkg::geo_t      item,
  output logic                out_valid,
  output scpk_pkg::out_item_t out_data
);

  logic [31:0] nl;
  logic [31:0] omf;

  always_comb begin
    case (row)
      2'd0:    nl = item.nrm[0];
      2'd1:    nl = item.nrm[1];
      2'd2:    nl = item.nrm[2];
      default: nl = '0;
    endcase
    omf = scpk_pkg::sat32({2'b00, scpk_pkg::Q_ONE} - {{2{item.f[31]}}, item.f});
  end

  // stage 1: n n^T row, penalty times gap
  logic                  r1_vld;
  logic [1:0]            r1_row;
  logic [2:0][31:0]      r1_nn;
  logic [31:0]           r1_egn;
  logic [31:0]           r1_omf;
  logic [31:0]           r1_f;
  logic [31:0]           r1_nl;
  logic [2:0][31:0]      r1_vel;
  scpk_pkg::pair_flags_t r1_fl;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_vld <= 1'b0;
    end else if (en) begin
      r1_vld <= in_valid;
    end
    if (en) begin
      r1_row <= row;
      for (int m = 0; m < 3; m++) begin
        r1_nn[m] <= scpk_pkg::qmul(nl, item.nrm[m]);
      end
      r1_egn <= scpk_pkg::qmul({1'b0, cfg.epn}, item.gn);
      r1_omf <= omf;
      r1_f   <= item.f;
      r1_nl  <= nl;
      r1_vel <= item.vel;
      r1_fl  <= item.flags;
    end
  end

  // stage 2: (1-f) n n^T, damping row, static load
  logic                  r2_vld;
  logic [1:0]            r2_row;
  logic [2:0][31:0]      r2_t;
  logic [2:0][31:0]      r2_damp;
  logic [31:0]           r2_load;
  logic [31:0]           r2_f;
  logic [2:0][31:0]      r2_vel;
  scpk_pkg::pair_flags_t r2_fl;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_vld <= 1'b0;
    end else if (en) begin
      r2_vld <= r1_vld;
    end
    if (en) begin
      r2_row <= r1_row;
      for (int m = 0; m < 3; m++) begin
        r2_t[m]    <= scpk_pkg::qmul(r1_omf, r1_nn[m]);
        r2_damp[m] <= scpk_pkg::qmul({1'b0, cfg.damp}, r1_nn[m]);
      end
      r2_load <= scpk_pkg::qmul(r1_egn, r1_nl);
      r2_f    <= r1_f;
      r2_vel  <= r1_vel;
      r2_fl   <= r1_fl;
    end
  end

  // stage 3: static stiffness, damping terms of the dynamic case
  logic [2:0][31:0] inner;

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      inner[m] = scpk_pkg::sadd((2'(m) == r2_row) ? r2_f : 32'd0, r2_t[m]);
    end
  end

  logic                  r3_vld;
  logic [1:0]            r3_row;
  logic [2:0][31:0]      r3_stiff;
  logic [2:0][31:0]      r3_ad;
  logic [2:0][31:0]      r3_dv;
  logic [2:0][31:0]      r3_damp;
  logic [31:0]           r3_load;
  scpk_pkg::pair_flags_t r3_fl;

  always_ff @(posedge clk) begin
    if (rst) begin
      r3_vld <= 1'b0;
    end else if (en) begin
      r3_vld <= r2_vld;
    end
    if (en) begin
      r3_row <= r2_row;
      for (int m = 0; m < 3; m++) begin
        r3_stiff[m] <= scpk_pkg::qmul({1'b0, cfg.epn}, inner[m]);
        r3_ad[m]    <= scpk_pkg::qmul({1'b0, cfg.gain}, r2_damp[m]);
        r3_dv[m]    <= scpk_pkg::qmul(r2_damp[m], r2_vel[m]);
      end
      r3_damp <= r2_damp;
      r3_load <= r2_load;
      r3_fl   <= r2_fl;
    end
  end

  // stage 4: dynamic sums, zero when not in contact or at zero distance
  logic [2:0][31:0] stiff_fin;
  logic [2:0][31:0] damp_fin;
  logic [31:0]      load_fin;

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      stiff_fin[m] = cfg.dyn ? scpk_pkg::sadd(r3_stiff[m], r3_ad[m]) : r3_stiff[m];
      damp_fin[m]  = r3_damp[m];
    end
    load_fin = cfg.dyn
             ? scpk_pkg::sadd(r3_load, scpk_pkg::sadd3(r3_dv[0], r3_dv[1], r3_dv[2]))
             : r3_load;
    if (!r3_fl.active) begin
      stiff_fin = '0;
      damp_fin  = '0;
      load_fin  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= r3_vld;
    end
    if (en) begin
      out_data.row_index      <= r3_row;
      out_data.stiff_col_x    <= stiff_fin[0];
      out_data.stiff_col_y    <= stiff_fin[1];
      out_data.stiff_col_z    <= stiff_fin[2];
      out_data.damp_col_x     <= damp_fin[0];
      out_data.damp_col_y     <= damp_fin[1];
      out_data.damp_col_z     <= damp_fin[2];
      out_data.load_component <= load_fin;
      out_data.in_contact     <= r3_fl.contact;
      out_data.near           <= r3_fl.near;
      out_data.last_row       <= (r3_row == scpk_pkg::ROW_LAST);
    end
  end

endmodule

/* design/sphere_contact_penalty_kernel_unit.sv */
// ----------------------------------------------------------------------------
// sphere_contact_penalty_kernel_unit
// sphere to sphere penalty contact: three block rows per pair
// ----------------------------------------------------------------------------
//
//   channel  signals                          transaction
//   -------  -------------------------------  -------------------------------
//   cfg      cfg_wr_en cfg_index cfg_wdata    one register write
//   in       in_valid in_stall in_data        one sphere pair
//   out      out_valid out_stall out_data     one row (three per pair)
//
// a pair yields three rows: the result channel carries one row a cycle while
// out_stall is low, and the row sequencer holds the geometry pipeline while
// it emits them; the root takes one bit per stage (34) and the divider one
// quotient bit per stage (31)
// reset clears valid bits, the sequencer and the registers; no clearing pass
// out_stall freezes every stage at once, so no transaction is lost or repeated
//
`timescale 1ns / 1ps

`include "sphere_contact_penalty_kernel_unit_assert.svh"

module sphere_contact_penalty_kernel_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [scpk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [30:0]                      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  scpk_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output scpk_pkg::out_item_t              out_data
);

  // configuration registers
  scpk_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        scpk_pkg::REG_NORMAL_PENALTY: cfg.epn  <= cfg_wdata;
        scpk_pkg::REG_DAMPING_COEFF:  cfg.damp <= cfg_wdata;
        scpk_pkg::REG_PROXIMITY:      cfg.prox <= cfg_wdata;
        scpk_pkg::REG_NEWMARK_GAIN:   cfg.gain <= cfg_wdata;
        scpk_pkg::REG_DYNAMIC_MODE:   cfg.dyn  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a finished row is held by the sink; the geometry also waits while the sequencer is busy
  logic adv;
  logic front_adv;
  logic seq_free;

  assign adv       = !out_valid || !out_stall;
  assign front_adv = adv && seq_free;
  assign in_stall  = !front_adv;

  // geometry: distance, gap, normal and gap ratio
  logic           geo_valid;
  scpk_pkg::geo_t geo_data;

  scpk_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (front_adv),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (geo_valid),
    .out_data  (geo_data)
  );

  // row sequencer: one pair in, rows 0, 1 and 2 out on consecutive moves
  logic           seq_valid;
  logic [1:0]     seq_row;
  scpk_pkg::geo_t seq_item;

  assign seq_free = !seq_valid || (seq_row == scpk_pkg::ROW_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_valid <= 1'b0;
      seq_row   <= scpk_pkg::ROW_FIRST;
    end else if (adv) begin
      if (seq_free) begin
        seq_valid <= geo_valid;
        seq_row   <= scpk_pkg::ROW_FIRST;
      end else begin
        seq_row   <= seq_row + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && seq_free) begin
      seq_item <= geo_data;
    end
  end

  // per-row arithmetic, output register at its end
  scpk_rows u_rows (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .cfg       (cfg),
    .in_valid  (seq_valid),
    .row       (seq_row),
    .item      (seq_item),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // rows of one pair leave back to back
  `SCPK_ASSERT_NEXT(a_row_order, clk, rst, out_valid && !out_stall && !out_data.last_row, out_valid && (out_data.row_index == $past(out_data.row_index) + 2'd1))

  // a pair is only taken while the sequencer can hand over
  `SCPK_ASSERT_IMPL(a_take_when_free, clk, rst, in_valid && !in_stall, !seq_valid || (seq_row == scpk_pkg::ROW_LAST))

  // no contact means an empty row
  `SCPK_ASSERT_IMPL(a_no_contact_zero, clk, rst, out_valid && !out_data.in_contact, (out_data.stiff_col_x == '0) && (out_data.damp_col_y == '0) && (out_data.load_component == '0))

endmodule
